// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

  // fixed field widths
  localparam int SAMP_W = 16;
  localparam int TIDX_W = 10;
  localparam int TL_W   = 11;
  localparam int SL_W   = 20;
  localparam int CFG_W  = 20;
  localparam int PIDX_W = 20;
  localparam int CORR_W = 42;
  localparam int HALF_W = CORR_W / 2;
  localparam int MAG_W  = 2 * CORR_W;

  localparam logic [TL_W-1:0] TRAIN_LENGTH_RST = 11'd800;
  localparam logic [SL_W-1:0] SEARCH_LIMIT_RST = 20'd10180;

  localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  localparam logic REQ_TAP  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef enum logic [0:0] {
    REG_TRAIN_LENGTH = 1'b0,
    REG_SEARCH_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
  } cplx_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_INSERT,
    RING_FWD,
    RING_BACK
  } ring_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FWD,
    S_BACK,
    S_MAG,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/training_sequence_correlator.sv =====
// Sliding complex correlator against a loaded training sequence. Taps (Q1.15) are
// written one per input word with req_type 0; data samples (req_type 1) shift into a
// ring of MAX_TAPS sample cells. Once L = train_length samples of a frame are in, each
// new sample closes the window starting L-1 samples back, and if that start is below
// search_limit the block forms sum(sample * conj(tap)), saturates each part to 42 bits
// and keeps the first start with the greatest squared magnitude. The data word
// marked last_sample emits peak_index, peak_real, peak_imag, found and too_short and
// clears the search. A tap load, or a sample that closes no window and is not last,
// leaves the block ready for the next word. A sample that closes a window holds off
// input while one complex multiply-accumulate walks the ring L cells forward while
// reading the tap memory, the ring steps back L-1 cells to realign, and a 6-step
// squared magnitude runs on a single 21x21 multiplier. The last word of a frame then
// waits to emit while the previous result is still held in the output register.
// Config must be written only while the block is idle; the block does not enforce it.
module training_sequence_correlator #(
  parameter int MAX_TAPS  = 1024,
  parameter int MAX_FRAME = 1048576
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [tsc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [tsc_pkg::TIDX_W-1:0]          tap_index,
  input  logic signed [tsc_pkg::SAMP_W-1:0]   sample_real,
  input  logic signed [tsc_pkg::SAMP_W-1:0]   sample_imag,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tsc_pkg::PIDX_W-1:0]          peak_index,
  output logic signed [tsc_pkg::CORR_W-1:0]   peak_real,
  output logic signed [tsc_pkg::CORR_W-1:0]   peak_imag,
  output logic                                found,
  output logic                                too_short
);

  localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LEN_W  = $clog2(MAX_TAPS + 1);
  localparam int TLC_W  = (LEN_W > tsc_pkg::TL_W) ? LEN_W : tsc_pkg::TL_W;
  localparam int TIX_W  = ((TAP_AW > tsc_pkg::TIDX_W) ? TAP_AW : tsc_pkg::TIDX_W) + 1;
  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int LC_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SLC_W  = (CNT_W > tsc_pkg::SL_W) ? CNT_W : tsc_pkg::SL_W;
  localparam int ACC_W  = 33 + $clog2(MAX_TAPS);
  localparam int SAT_W  = (ACC_W > tsc_pkg::CORR_W) ? ACC_W : tsc_pkg::CORR_W;

  tsc_pkg::state_t   state;
  tsc_pkg::state_t   state_next;
  tsc_pkg::ring_op_t ring_op;

  logic [tsc_pkg::TL_W-1:0] train_length;
  logic [tsc_pkg::SL_W-1:0] search_limit;
  logic [TLC_W-1:0]         tl_ext;
  logic [LEN_W-1:0]         len;

  logic in_fire;
  logic data_fire;
  logic tap_fire;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_inc;
  logic             cnt_room;
  logic [CNT_W-1:0] win_start;
  logic             eval_now;
  logic             frame_end;

  logic [TIX_W-1:0]  tap_ext;
  logic              tap_ok;
  logic [TAP_AW-1:0] tap_waddr;
  logic [TAP_AW-1:0] tap_raddr;
  logic [TAP_AW-1:0] j;
  logic              at_end;

  tsc_pkg::cplx_t in_sample;
  tsc_pkg::cplx_t ring_head_in;
  tsc_pkg::cplx_t ring_q [MAX_TAPS];
  tsc_pkg::cplx_t tap_mem [MAX_TAPS];
  tsc_pkg::cplx_t tap_a;
  tsc_pkg::cplx_t win_a;

  logic                    mac_issue;
  logic                    va;
  logic                    vb;
  logic                    pipe_empty;
  logic signed [31:0]      pr_rr;
  logic signed [31:0]      pr_ii;
  logic signed [31:0]      pr_ir;
  logic signed [31:0]      pr_ri;
  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;

  logic                               mag_start;
  logic                               mag_done;
  logic [tsc_pkg::MAG_W-1:0]          mag_val;
  logic signed [tsc_pkg::CORR_W-1:0]  sat_re;
  logic signed [tsc_pkg::CORR_W-1:0]  sat_im;
  logic signed [tsc_pkg::CORR_W-1:0]  cand_re;
  logic signed [tsc_pkg::CORR_W-1:0]  cand_im;
  logic [tsc_pkg::PIDX_W-1:0]         cand_index;

  logic signed [tsc_pkg::CORR_W-1:0]  best_re;
  logic signed [tsc_pkg::CORR_W-1:0]  best_im;
  logic [tsc_pkg::PIDX_W-1:0]         best_index;
  logic [tsc_pkg::MAG_W-1:0]          best_mag;
  logic                               emit;

  function automatic logic signed [tsc_pkg::CORR_W-1:0] sat_corr(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SAT_W'(tsc_pkg::CORR_MAX)) return tsc_pkg::CORR_MAX;
    if (w < SAT_W'(tsc_pkg::CORR_MIN)) return tsc_pkg::CORR_MIN;
    return tsc_pkg::CORR_W'(w);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      train_length <= tsc_pkg::TRAIN_LENGTH_RST;
      search_limit <= tsc_pkg::SEARCH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsc_pkg::REG_TRAIN_LENGTH: train_length <= cfg_data[tsc_pkg::TL_W-1:0];
        tsc_pkg::REG_SEARCH_LIMIT: search_limit <= cfg_data[tsc_pkg::SL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, anything past the tap store is clipped
  assign tl_ext = TLC_W'(train_length);
  always_comb begin
    if (tl_ext == '0) begin
      len = LEN_W'(1);
    end else if (tl_ext > TLC_W'(MAX_TAPS)) begin
      len = LEN_W'(MAX_TAPS);
    end else begin
      len = LEN_W'(tl_ext);
    end
  end

  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && (req_type == tsc_pkg::REQ_DATA);
  assign tap_fire  = in_fire && (req_type == tsc_pkg::REQ_TAP);

  assign in_sample.re = sample_real;
  assign in_sample.im = sample_imag;

  assign cnt_inc   = count + CNT_W'(1);
  assign cnt_room  = count < CNT_W'(MAX_FRAME);
  assign win_start = CNT_W'(LC_W'(cnt_inc) - LC_W'(len));
  assign eval_now  = data_fire && cnt_room && (LC_W'(cnt_inc) >= LC_W'(len))
                     && (SLC_W'(win_start) < SLC_W'(search_limit));

  assign tap_ext   = TIX_W'(tap_index);
  assign tap_ok    = tap_ext < TIX_W'(MAX_TAPS);
  assign tap_waddr = TAP_AW'(tap_ext);

  assign at_end     = LEN_W'(j) == (len - LEN_W'(1));
  assign tap_raddr  = TAP_AW'(len - LEN_W'(1) - LEN_W'(j));
  assign pipe_empty = !va && !vb;

  // sample ring: cell 0 is the newest sample, cell i is i samples back
  assign ring_head_in = (ring_op == tsc_pkg::RING_INSERT) ? in_sample : ring_q[MAX_TAPS-1];

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_ring
    if (i == 0) begin : g_head
      tsc_cell u_cell (
        .clk  (clk),
        .op   (ring_op),
        .prev (ring_head_in),
        .next (ring_q[(i + 1) % MAX_TAPS]),
        .q    (ring_q[i])
      );
    end else begin : g_body
      tsc_cell u_cell (
        .clk  (clk),
        .op   (ring_op),
        .prev (ring_q[i-1]),
        .next (ring_q[(i + 1) % MAX_TAPS]),
        .q    (ring_q[i])
      );
    end
  end

  // state register and next state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tsc_pkg::S_IDLE: begin
        if (eval_now) begin
          state_next = tsc_pkg::S_FWD;
        end else if (data_fire && last_sample) begin
          state_next = tsc_pkg::S_EMIT;
        end
      end
      tsc_pkg::S_FWD: begin
        if (at_end) state_next = tsc_pkg::S_BACK;
      end
      tsc_pkg::S_BACK: begin
        if (j == '0 && pipe_empty) state_next = tsc_pkg::S_MAG;
      end
      tsc_pkg::S_MAG: begin
        if (mag_done) state_next = frame_end ? tsc_pkg::S_EMIT : tsc_pkg::S_IDLE;
      end
      tsc_pkg::S_EMIT: begin
        if (emit) state_next = tsc_pkg::S_IDLE;
      end
      default: state_next = tsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ring_op   = tsc_pkg::RING_HOLD;
    mac_issue = 1'b0;
    mag_start = 1'b0;
    emit      = 1'b0;
    case (state)
      tsc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (data_fire) ring_op = tsc_pkg::RING_INSERT;
      end
      tsc_pkg::S_FWD: begin
        mac_issue = 1'b1;
        if (!at_end) ring_op = tsc_pkg::RING_FWD;
      end
      tsc_pkg::S_BACK: begin
        if (j != '0) begin
          ring_op = tsc_pkg::RING_BACK;
        end else if (pipe_empty) begin
          mag_start = 1'b1;
        end
      end
      tsc_pkg::S_MAG: ;
      tsc_pkg::S_EMIT: emit = !out_valid || out_ready;
      default: ;
    endcase
  end

  // ring position follows the rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (ring_op == tsc_pkg::RING_FWD) begin
      j <= j + TAP_AW'(1);
    end else if (ring_op == tsc_pkg::RING_BACK) begin
      j <= j - TAP_AW'(1);
    end
  end

  // tap store and read stage
  always_ff @(posedge clk) begin
    if (tap_fire && tap_ok) begin
      tap_mem[tap_waddr] <= in_sample;
    end
    if (mac_issue) begin
      tap_a <= tap_mem[tap_raddr];
      win_a <= ring_q[0];
    end
  end

  // sample * conj(tap): multiply stage, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= mac_issue;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va) begin
      pr_rr <= win_a.re * tap_a.re;
      pr_ii <= win_a.im * tap_a.im;
      pr_ir <= win_a.im * tap_a.re;
      pr_ri <= win_a.re * tap_a.im;
    end
    if (in_fire) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (vb) begin
      acc_re <= acc_re + ACC_W'(pr_rr) + ACC_W'(pr_ii);
      acc_im <= acc_im + ACC_W'(pr_ir) - ACC_W'(pr_ri);
    end
  end

  assign sat_re = sat_corr(acc_re);
  assign sat_im = sat_corr(acc_im);

  tsc_magsq u_magsq (
    .clk   (clk),
    .rst   (rst),
    .start (mag_start),
    .re    (sat_re),
    .im    (sat_im),
    .done  (mag_done),
    .mag   (mag_val)
  );

  always_ff @(posedge clk) begin
    if (eval_now) begin
      cand_index <= tsc_pkg::PIDX_W'(win_start);
    end
    if (mag_start) begin
      cand_re <= sat_re;
      cand_im <= sat_im;
    end
  end

  // frame search state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      frame_end  <= 1'b0;
      best_re    <= '0;
      best_im    <= '0;
      best_index <= '0;
      best_mag   <= '0;
    end else begin
      if (data_fire) begin
        frame_end <= last_sample;
        if (cnt_room) count <= cnt_inc;
      end
      // strict compare keeps the first start on a tie
      if (state == tsc_pkg::S_MAG && mag_done && mag_val > best_mag) begin
        best_re    <= cand_re;
        best_im    <= cand_im;
        best_index <= cand_index;
        best_mag   <= mag_val;
      end
      if (emit) begin
        count      <= '0;
        best_re    <= '0;
        best_im    <= '0;
        best_index <= '0;
        best_mag   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      peak_index <= best_index;
      peak_real  <= best_re;
      peak_imag  <= best_im;
      found      <= (best_re != '0) || (best_im != '0);
      too_short  <= LC_W'(count) < LC_W'(len);
    end
  end

endmodule

// ===== rtl/tsc_cell.sv =====
module tsc_cell (
  input  logic              clk,
  input  tsc_pkg::ring_op_t op,
  input  tsc_pkg::cplx_t    prev,
  input  tsc_pkg::cplx_t    next,
  output tsc_pkg::cplx_t    q
);

  // insert and back rotation both pull from the previous cell
  always_ff @(posedge clk) begin
    case (op)
      tsc_pkg::RING_INSERT: q <= prev;
      tsc_pkg::RING_BACK:   q <= prev;
      tsc_pkg::RING_FWD:    q <= next;
      tsc_pkg::RING_HOLD:   q <= q;
      default:              q <= q;
    endcase
  end

endmodule

// ===== rtl/tsc_magsq.sv =====
module tsc_magsq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tsc_pkg::CORR_W-1:0]   re,
  input  logic signed [tsc_pkg::CORR_W-1:0]   im,
  output logic                                done,
  output logic        [tsc_pkg::MAG_W-1:0]    mag
);

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [tsc_pkg::CORR_W-1:0]   ma;
  logic [tsc_pkg::CORR_W-1:0]   mb;
  logic                         busy;
  logic [2:0]                   step;
  logic [2:0]                   prod_step;
  logic                         pv;
  logic [2*tsc_pkg::HALF_W-1:0] prod;
  logic [tsc_pkg::CORR_W-1:0]   part;
  logic [tsc_pkg::HALF_W-1:0]   op_x;
  logic [tsc_pkg::HALF_W-1:0]   op_y;
  logic [tsc_pkg::MAG_W-1:0]    term;

  function automatic logic [tsc_pkg::CORR_W-1:0] abs_corr(
    input logic signed [tsc_pkg::CORR_W-1:0] v
  );
    return v[tsc_pkg::CORR_W-1] ? (~v + tsc_pkg::CORR_W'(1)) : v;
  endfunction

  // a^2 = lo*lo + (hi*lo << half+1) + (hi*hi << 2*half), real part then imaginary
  always_comb begin
    part = (step < 3'd3) ? ma : mb;
    case (step)
      3'd0, 3'd3: begin
        op_x = part[tsc_pkg::HALF_W-1:0];
        op_y = part[tsc_pkg::HALF_W-1:0];
      end
      3'd1, 3'd4: begin
        op_x = part[tsc_pkg::CORR_W-1:tsc_pkg::HALF_W];
        op_y = part[tsc_pkg::HALF_W-1:0];
      end
      3'd2, 3'd5: begin
        op_x = part[tsc_pkg::CORR_W-1:tsc_pkg::HALF_W];
        op_y = part[tsc_pkg::CORR_W-1:tsc_pkg::HALF_W];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  always_comb begin
    case (prod_step)
      3'd1, 3'd4: term = tsc_pkg::MAG_W'(prod) << (tsc_pkg::HALF_W + 1);
      3'd2, 3'd5: term = tsc_pkg::MAG_W'(prod) << tsc_pkg::CORR_W;
      default:    term = tsc_pkg::MAG_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= pv && (prod_step == LAST_STEP);
      pv   <= busy;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= abs_corr(re);
      mb  <= abs_corr(im);
      mag <= '0;
    end else if (pv) begin
      mag <= mag + term;
    end
    if (busy) begin
      prod      <= op_x * op_y;
      prod_step <= step;
    end
  end

endmodule

// ===== rtl/tsc_checker.sv =====
module tsc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               req_type,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tsc_pkg::PIDX_W-1:0]         peak_index,
  input logic signed [tsc_pkg::CORR_W-1:0]  peak_real,
  input logic signed [tsc_pkg::CORR_W-1:0]  peak_imag,
  input logic                               found,
  input logic                               too_short
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  // tap loads never stall the input
  a_tap_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == tsc_pkg::REQ_TAP |=> in_ready)
    else $error("input stalled after a tap load");

  a_found_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> found == (peak_real != '0 || peak_imag != '0))
    else $error("found flag disagrees with peak value");

  a_short_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> !found && peak_index == '0)
    else $error("short frame reported a peak");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(peak_index)
      && $stable(peak_real) && $stable(peak_imag))
    else $error("stalled result word changed");

endmodule

bind training_sequence_correlator tsc_checker u_tsc_checker (.*);

// ===== tb/testbench.sv =====
module testbench;

  localparam int TAP_DEPTH   = 1024;
  localparam int FRAME_CAP   = 1048576;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_WORDS  = 550;
  localparam int WIDE_LEN    = 128;

  localparam logic signed [tsc_pkg::SAMP_W-1:0] SAMP_MIN  = 16'sh8000;
  localparam logic signed [tsc_pkg::SAMP_W-1:0] SAMP_MAX  = 16'sh7fff;
  localparam logic [tsc_pkg::SL_W-1:0]          LIMIT_ALL = '1;

  typedef struct packed {
    logic [tsc_pkg::PIDX_W-1:0]        index;
    logic signed [tsc_pkg::CORR_W-1:0] re;
    logic signed [tsc_pkg::CORR_W-1:0] im;
    logic                              found;
    logic                              too_short;
  } peak_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  logic [0:0]                        cfg_index;
  logic [tsc_pkg::CFG_W-1:0]         cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic                              req_type;
  logic [tsc_pkg::TIDX_W-1:0]        tap_index;
  logic signed [tsc_pkg::SAMP_W-1:0] sample_real;
  logic signed [tsc_pkg::SAMP_W-1:0] sample_imag;
  logic                              last_sample;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [tsc_pkg::PIDX_W-1:0]        peak_index;
  logic signed [tsc_pkg::CORR_W-1:0] peak_real;
  logic signed [tsc_pkg::CORR_W-1:0] peak_imag;
  logic                              found;
  logic                              too_short;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int words_sent    = 0;
  int peaks_checked = 0;
  int cycle_count   = 0;

  // correlator state as the testbench sees it
  logic [tsc_pkg::TL_W-1:0]          train_len_q;
  logic [tsc_pkg::SL_W-1:0]          search_lim_q;
  logic signed [tsc_pkg::SAMP_W-1:0] tap_re [TAP_DEPTH];
  logic signed [tsc_pkg::SAMP_W-1:0] tap_im [TAP_DEPTH];
  logic signed [tsc_pkg::SAMP_W-1:0] ring_re [TAP_DEPTH];
  logic signed [tsc_pkg::SAMP_W-1:0] ring_im [TAP_DEPTH];
  int unsigned                       ring_head;
  int unsigned                       frame_count;
  logic signed [tsc_pkg::CORR_W-1:0] best_re;
  logic signed [tsc_pkg::CORR_W-1:0] best_im;
  logic [tsc_pkg::PIDX_W-1:0]        best_idx;
  peak_t                             pending_peaks[$];

  training_sequence_correlator #(
    .MAX_TAPS (TAP_DEPTH),
    .MAX_FRAME(FRAME_CAP)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .tap_index  (tap_index),
    .sample_real(sample_real),
    .sample_imag(sample_imag),
    .last_sample(last_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .peak_index (peak_index),
    .peak_real  (peak_real),
    .peak_imag  (peak_imag),
    .found      (found),
    .too_short  (too_short)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d peak reports pending", cycle_count,
               pending_peaks.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned active_length();
    if (train_len_q == 0) return 1;
    if (train_len_q > TAP_DEPTH) return TAP_DEPTH;
    return train_len_q;
  endfunction

  function automatic logic signed [tsc_pkg::CORR_W-1:0] clamp_corr(longint v);
    if (v > tsc_pkg::CORR_MAX) return tsc_pkg::CORR_MAX;
    if (v < tsc_pkg::CORR_MIN) return tsc_pkg::CORR_MIN;
    return tsc_pkg::CORR_W'(v);
  endfunction

  function automatic logic [tsc_pkg::MAG_W-1:0] power_of(longint re, longint im);
    logic [tsc_pkg::MAG_W-1:0] a, b;
    a = tsc_pkg::MAG_W'((re < 0) ? -re : re);
    b = tsc_pkg::MAG_W'((im < 0) ? -im : im);
    return a * a + b * b;
  endfunction

  // sample times conjugate tap over the window ending at the newest sample
  function automatic void correlate_window(int unsigned len, int unsigned start);
    longint                            acc_re, acc_im;
    int unsigned                       k, slot;
    logic signed [tsc_pkg::CORR_W-1:0] c_re, c_im;
    acc_re = 0;
    acc_im = 0;
    for (k = 0; k < len; k++) begin
      slot = (ring_head + TAP_DEPTH - (len - 1 - k)) % TAP_DEPTH;
      acc_re += longint'(ring_re[slot]) * tap_re[k] + longint'(ring_im[slot]) * tap_im[k];
      acc_im += longint'(ring_im[slot]) * tap_re[k] - longint'(ring_re[slot]) * tap_im[k];
    end
    c_re = clamp_corr(acc_re);
    c_im = clamp_corr(acc_im);
    if (power_of(longint'(c_re), longint'(c_im)) >
        power_of(longint'(best_re), longint'(best_im))) begin
      best_re  = c_re;
      best_im  = c_im;
      best_idx = tsc_pkg::PIDX_W'(start);
    end
  endfunction

  function automatic void advance_search(logic kind, logic [tsc_pkg::TIDX_W-1:0] idx,
                                         logic signed [tsc_pkg::SAMP_W-1:0] re,
                                         logic signed [tsc_pkg::SAMP_W-1:0] im,
                                         logic last);
    int unsigned len, start;
    peak_t       rec;
    len = active_length();
    if (kind == tsc_pkg::REQ_TAP) begin
      tap_re[idx] = re;
      tap_im[idx] = im;
      return;
    end
    ring_head = (ring_head + 1) % TAP_DEPTH;
    ring_re[ring_head] = re;
    ring_im[ring_head] = im;
    if (frame_count < FRAME_CAP) begin
      frame_count++;
      if (frame_count >= len) begin
        start = frame_count - len;
        if (start < search_lim_q) correlate_window(len, start);
      end
    end
    if (!last) return;
    rec.index     = best_idx;
    rec.re        = best_re;
    rec.im        = best_im;
    rec.found     = (best_re != 0) || (best_im != 0);
    rec.too_short = (frame_count < len);
    pending_peaks.push_back(rec);
    frame_count = 0;
    best_re     = '0;
    best_im     = '0;
    best_idx    = '0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 40) $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_peaks
    peak_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_peaks.size() == 0) begin
        report_mismatch("peak report with none pending, peak_index",
                        longint'(peak_index), 0);
      end else begin
        want = pending_peaks.pop_front();
        peaks_checked++;
        if (peak_index !== want.index)
          report_mismatch("peak_index", longint'(peak_index), longint'(want.index));
        if (peak_real !== want.re)
          report_mismatch("peak_real", longint'(peak_real), longint'(want.re));
        if (peak_imag !== want.im)
          report_mismatch("peak_imag", longint'(peak_imag), longint'(want.im));
        if (found !== want.found)
          report_mismatch("found", longint'(found), longint'(want.found));
        if (too_short !== want.too_short)
          report_mismatch("too_short", longint'(too_short), longint'(want.too_short));
      end
    end
  end

  task automatic send_word(input logic kind, input logic [tsc_pkg::TIDX_W-1:0] idx,
                           input logic signed [tsc_pkg::SAMP_W-1:0] re,
                           input logic signed [tsc_pkg::SAMP_W-1:0] im, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    req_type    = kind;
    tap_index   = idx;
    sample_real = re;
    sample_imag = im;
    last_sample = last;
    do @(posedge clk); while (!in_ready);
    advance_search(kind, idx, re, im, last);
    words_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [tsc_pkg::TL_W-1:0] tl,
                            input logic [tsc_pkg::SL_W-1:0] sl);
    logic [tsc_pkg::CFG_W-tsc_pkg::TL_W-1:0] junk;
    hold_until_drained();
    // a sample that closes a window may still be in flight
    repeat (2 * active_length() + 16) @(negedge clk);
    junk      = ($bits(junk))'($urandom);
    cfg_we    = 1'b1;
    cfg_index = tsc_pkg::REG_TRAIN_LENGTH;
    cfg_data  = {junk, tl};
    @(negedge clk);
    cfg_index = tsc_pkg::REG_SEARCH_LIMIT;
    cfg_data  = sl;
    @(negedge clk);
    cfg_we = 1'b0;
    train_len_q  = tl;
    search_lim_q = sl;
  endtask

  function automatic logic signed [tsc_pkg::SAMP_W-1:0] pick_part();
    logic [tsc_pkg::SAMP_W-1:0] v;
    v = tsc_pkg::SAMP_W'($urandom);
    case ($urandom_range(7))
      0: return SAMP_MIN;
      1: return SAMP_MAX;
      2: return '0;
      3: return $signed(tsc_pkg::SAMP_W'($urandom_range(16))) - 16'sd8;
      default: return v;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // reset length of 800 taps: a tiny frame is too short and reads no tap
    send_word(tsc_pkg::REQ_DATA, 10'h3ff, SAMP_MIN, SAMP_MAX, 1'b0);
    send_word(tsc_pkg::REQ_DATA, 10'h000, SAMP_MAX, SAMP_MIN, 1'b1);
  endtask

  task automatic test_tap_loads();
    send_word(tsc_pkg::REQ_TAP, 10'd0, 16'sd16384, 16'sd0, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd1, SAMP_MAX, SAMP_MIN, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd2, SAMP_MIN, SAMP_MAX, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd3, SAMP_MIN, SAMP_MIN, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd4, SAMP_MAX, SAMP_MAX, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd5, 16'sd0, 16'sd0, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd6, 16'sd1, -16'sd1, 1'b0);
    // last mark on a tap load must not close a frame
    send_word(tsc_pkg::REQ_TAP, 10'd7, -16'sd1, 16'sd1, 1'b1);
  endtask

  task automatic test_peak_tie();
    // length 0 acts as one tap; equal magnitudes keep the first start
    set_config(11'd0, LIMIT_ALL);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd3, 16'sd4, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd4, -16'sd3, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, -16'sd5, 16'sd0, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd0, 16'sd5, 1'b1);
  endtask

  task automatic test_zero_search();
    set_config(11'd1, 20'd0);
    send_word(tsc_pkg::REQ_DATA, '0, SAMP_MAX, SAMP_MAX, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, SAMP_MIN, SAMP_MIN, 1'b1);
  endtask

  task automatic test_short_and_empty();
    set_config(11'd8, LIMIT_ALL);
    send_word(tsc_pkg::REQ_DATA, '0, SAMP_MAX, 16'sd7, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd9, SAMP_MIN, 1'b1);
    set_config(11'd2, 20'd5);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd0, 16'sd0, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd0, 16'sd0, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_midframe_tap();
    set_config(11'd2, LIMIT_ALL);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd100, -16'sd200, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, -16'sd300, 16'sd50, 1'b0);
    send_word(tsc_pkg::REQ_TAP, 10'd1, 16'sd12345, -16'sd2222, 1'b1);
    send_word(tsc_pkg::REQ_DATA, '0, SAMP_MAX, 16'sd1, 1'b0);
    send_word(tsc_pkg::REQ_DATA, '0, 16'sd77, SAMP_MIN, 1'b1);
  endtask

  task automatic test_wide_window();
    int unsigned k;
    // extreme taps against extreme samples over a long window
    for (k = 0; k < WIDE_LEN; k++)
      send_word(tsc_pkg::REQ_TAP, tsc_pkg::TIDX_W'(k), SAMP_MIN,
                (k % 3 == 0) ? SAMP_MAX : SAMP_MIN, 1'b0);
    set_config(tsc_pkg::TL_W'(WIDE_LEN), 20'd3);
    for (k = 0; k < WIDE_LEN + 2; k++)
      send_word(tsc_pkg::REQ_DATA, tsc_pkg::TIDX_W'($urandom),
                (k < WIDE_LEN) ? SAMP_MIN : pick_part(),
                (k < WIDE_LEN) ? SAMP_MIN : pick_part(), k == WIDE_LEN + 1);
    // lengths above the tap store act as the full store, so a short frame is too short
    set_config(11'd2047, 20'd1);
    for (k = 0; k < 3; k++)
      send_word(tsc_pkg::REQ_DATA, tsc_pkg::TIDX_W'($urandom), pick_part(), pick_part(),
                k == 2);
  endtask

  task automatic test_random_frames(input int budget);
    int unsigned                k, flen, stop_at;
    logic                       zero_frame;
    logic [tsc_pkg::TL_W-1:0]   tl;
    logic [tsc_pkg::SL_W-1:0]   sl;
    stop_at = words_sent + budget;
    for (k = 0; k < 32; k++)
      send_word(tsc_pkg::REQ_TAP, tsc_pkg::TIDX_W'(k), pick_part(), pick_part(),
                1'($urandom_range(1)));
    while (words_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        tl = tsc_pkg::TL_W'($urandom_range(32));
        case ($urandom_range(5))
          0: sl = '0;
          1: sl = tsc_pkg::SL_W'(1);
          2: sl = LIMIT_ALL;
          3: sl = tsc_pkg::SL_W'($urandom);
          default: sl = tsc_pkg::SL_W'($urandom_range(48, 1));
        endcase
        set_config(tl, sl);
      end else if ($urandom_range(4) == 0) begin
        hold_until_drained();
      end
      zero_frame = ($urandom_range(11) == 0);
      case ($urandom_range(9))
        0, 1: flen = $urandom_range(active_length(), 1);
        2: flen = $urandom_range(120, 60);
        default: flen = $urandom_range(40, 1);
      endcase
      for (k = 0; k < flen; k++) begin
        if ($urandom_range(15) == 0)
          send_word(tsc_pkg::REQ_TAP, tsc_pkg::TIDX_W'($urandom), pick_part(), pick_part(),
                    1'($urandom_range(1)));
        send_word(tsc_pkg::REQ_DATA, tsc_pkg::TIDX_W'($urandom),
                  zero_frame ? 16'sd0 : pick_part(),
                  zero_frame ? 16'sd0 : pick_part(), k == flen - 1);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = tsc_pkg::REG_TRAIN_LENGTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    req_type    = tsc_pkg::REQ_TAP;
    tap_index   = '0;
    sample_real = '0;
    sample_imag = '0;
    last_sample = 1'b0;
    train_len_q  = tsc_pkg::TRAIN_LENGTH_RST;
    search_lim_q = tsc_pkg::SEARCH_LIMIT_RST;
    for (int k = 0; k < TAP_DEPTH; k++) begin
      tap_re[k]  = '0;
      tap_im[k]  = '0;
      ring_re[k] = '0;
      ring_im[k] = '0;
    end
    ring_head   = 0;
    frame_count = 0;
    best_re     = '0;
    best_im     = '0;
    best_idx    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 87;
    test_reset_defaults();
    test_tap_loads();
    test_peak_tie();
    test_zero_search();
    test_short_and_empty();
    test_midframe_tap();
    test_wide_window();
    test_random_frames(RAND_WORDS);

    send_idle_pct = 87;
    recv_idle_pct = 28;
    test_random_frames(RAND_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(RAND_WORDS);

    hold_until_drained();
    repeat (2 * active_length() + 32) @(posedge clk);
    if (pending_peaks.size() != 0)
      report_mismatch("peak reports never produced", longint'(pending_peaks.size()), 0);
    $display("%0d words sent, %0d peak reports checked, %0d mismatches", words_sent,
             peaks_checked, error_count);
    $display("train lengths 0 to 2047, search limits 0 to max, windows up to %0d taps",
             WIDE_LEN);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
